// ===== sv/pidf_pkg.sv =====
// Shared types and constants for the filtered PID controller.
package pidf_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Fixed-width register fields
	localparam int ALPHA_BITS = 16;
	localparam int ALPHA_W    = ALPHA_BITS + 1;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;
	localparam int INV_DT_W   = 20;
	localparam int REG_IDX_W  = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KP       = 3'd0,
		REG_KI_DT    = 3'd1,
		REG_KD       = 3'd2,
		REG_IMAX     = 3'd3,
		REG_ALPHA    = 3'd4,
		REG_INV_DT   = 3'd5,
		REG_MODE     = 3'd6,
		REG_FF_GAIN  = 3'd7
	} pidf_reg_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_ALPHA,
		SH_FRAC
	} pidf_shift_t;

	typedef struct packed {
		logic        start;
		pidf_shift_t shift;
	} pidf_mul_req_t;

	typedef enum logic [2:0] {
		MS_IDLE,
		MS_LO,
		MS_HI,
		MS_ACC,
		MS_OUT
	} pidf_mul_state_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIFF,
		S_M_CHANGE,
		S_FILT_ADD,
		S_M_DRV,
		S_M_RAW,
		S_RAW_SUB,
		S_M_STEP,
		S_DRV_ADD,
		S_M_P,
		S_M_I,
		S_INT_ADD,
		S_INT_CLAMP,
		S_M_D,
		S_M_FF,
		S_SUM,
		S_OUT
	} pidf_state_t;

endpackage

// ===== sv/pid_controller_filtered.sv =====
// Filtered PID controller top level: registers, sequencer and datapath around one multiplier.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  cfg      | cfg_wr_en            | cfg_addr, cfg_wdata
//  in       | in_valid / in_stall  | sample, rate_setpoint, clear_integrator
//  out      | out_valid / out_stall| p_term, i_term, d_term, ff_term, pid_sum
//
// Each beat runs through the sequencer states from acceptance until its result is
// registered, and the next beat can be taken once the sequencer is idle again. The shared
// multiplier forms three to six products per beat in turn, between add, clamp and sum steps.
// Reset clears the filter, derivative and integrator; the next sample seeds the filter.
// in_stall is high from acceptance until the result moves into the output register,
// which holds it until taken; a result not yet taken delays the next one.
module pid_controller_filtered #(
	parameter int DATA_WIDTH = pidf_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidf_pkg::FRAC_BITS_DEF,
	localparam int CFG_W = (DATA_WIDTH > pidf_pkg::INV_DT_W) ? DATA_WIDTH : pidf_pkg::INV_DT_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pidf_pkg::REG_IDX_W-1:0]      cfg_addr,
	input  logic [CFG_W-1:0]                    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [DATA_WIDTH-1:0]        sample,
	input  logic signed [DATA_WIDTH-1:0]        rate_setpoint,
	input  logic                                clear_integrator,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [DATA_WIDTH-1:0]        p_term,
	output logic signed [DATA_WIDTH-1:0]        i_term,
	output logic signed [DATA_WIDTH-1:0]        d_term,
	output logic signed [DATA_WIDTH-1:0]        ff_term,
	output logic signed [DATA_WIDTH-1:0]        pid_sum
);

	localparam int OP_W = CFG_W + 1;
	localparam int XW   = DATA_WIDTH + 1;
	localparam int SW   = DATA_WIDTH + 2;
	localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [XW-1:0] v);
		if (v[XW-1] != v[XW-2]) begin
			return v[XW-1] ? D_MIN : D_MAX;
		end
		return $signed(v[DATA_WIDTH-1:0]);
	endfunction

	// configuration
	logic signed [DATA_WIDTH-1:0]        kp_q, ki_dt_q, kd_q, ff_gain_q;
	logic [DATA_WIDTH-2:0]               imax_q;
	logic [pidf_pkg::ALPHA_W-1:0]        alpha_q;
	logic [pidf_pkg::INV_DT_W-1:0]       inv_dt_q;
	logic                                mode_q;

	// controller state
	pidf_pkg::pidf_state_t               state_q, state_d;
	logic signed [DATA_WIDTH-1:0]        filt_q, drv_q, integ_q;
	logic                                first_pending_q;
	logic                                out_valid_q;

	// per-beat working registers
	logic signed [DATA_WIDTH-1:0]        sample_q, rate_q, t_q;
	logic signed [DATA_WIDTH-1:0]        p_q, i_q, d_q, ff_q, sum_q;
	logic signed [DATA_WIDTH-1:0]        p_out_q, i_out_q, d_out_q, ff_out_q, sum_out_q;

	// shared multiplier
	pidf_pkg::pidf_mul_req_t             mul_req;
	logic signed [OP_W-1:0]              op_a, op_b;
	logic                                mul_done;
	logic signed [DATA_WIDTH-1:0]        mul_res;

	logic                                in_take, out_free;
	logic [pidf_pkg::ALPHA_W-1:0]        alpha_eff;
	logic signed [OP_W-1:0]              alpha_op, inv_op, t_op;
	logic signed [DATA_WIDTH-1:0]        diff_in, filt_sum, raw_sub, drv_sum, int_sum;
	logic signed [DATA_WIDTH-1:0]        imax_pos, imax_neg, int_clamp;
	logic signed [SW-1:0]                sum3;
	logic signed [DATA_WIDTH-1:0]        sum3_sat;

	pidf_mul #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	assign in_take  = in_valid && (state_q == pidf_pkg::S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// alpha above one acts as one
	assign alpha_eff = (alpha_q > pidf_pkg::ALPHA_ONE) ? pidf_pkg::ALPHA_ONE : alpha_q;
	assign alpha_op  = $signed(OP_W'(alpha_eff));
	assign inv_op    = $signed(OP_W'(inv_dt_q));
	assign t_op      = OP_W'(t_q);

	assign diff_in  = sat_w(XW'(sample_q) - XW'(filt_q));
	assign filt_sum = sat_w(XW'(filt_q) + XW'(t_q));
	assign raw_sub  = sat_w(XW'(t_q) - XW'(drv_q));
	assign drv_sum  = sat_w(XW'(drv_q) + XW'(t_q));
	assign int_sum  = sat_w(XW'(integ_q) + XW'(t_q));

	assign imax_pos  = $signed({1'b0, imax_q});
	assign imax_neg  = -imax_pos;
	assign int_clamp = (integ_q < imax_neg) ? imax_neg :
	                   (integ_q > imax_pos) ? imax_pos : integ_q;

	assign sum3     = SW'(p_q) + SW'(i_q) + SW'(d_q);
	assign sum3_sat = (sum3 > SW'(D_MAX)) ? D_MAX :
	                  (sum3 < SW'(D_MIN)) ? D_MIN : sum3[DATA_WIDTH-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pidf_pkg::S_IDLE: begin
				if (in_valid) state_d = pidf_pkg::S_DIFF;
			end
			pidf_pkg::S_DIFF: begin
				if (!mode_q)              state_d = pidf_pkg::S_M_CHANGE;
				else if (inv_dt_q != '0)  state_d = pidf_pkg::S_M_RAW;
				else                      state_d = pidf_pkg::S_M_P;
			end
			pidf_pkg::S_M_CHANGE: begin
				if (mul_done) state_d = pidf_pkg::S_FILT_ADD;
			end
			pidf_pkg::S_FILT_ADD: begin
				state_d = (inv_dt_q != '0) ? pidf_pkg::S_M_DRV : pidf_pkg::S_M_P;
			end
			pidf_pkg::S_M_DRV: begin
				if (mul_done) state_d = pidf_pkg::S_M_P;
			end
			pidf_pkg::S_M_RAW: begin
				if (mul_done) state_d = pidf_pkg::S_RAW_SUB;
			end
			pidf_pkg::S_RAW_SUB:  state_d = pidf_pkg::S_M_STEP;
			pidf_pkg::S_M_STEP: begin
				if (mul_done) state_d = pidf_pkg::S_DRV_ADD;
			end
			pidf_pkg::S_DRV_ADD:  state_d = pidf_pkg::S_M_P;
			pidf_pkg::S_M_P: begin
				if (mul_done) state_d = (ki_dt_q != '0) ? pidf_pkg::S_M_I : pidf_pkg::S_M_D;
			end
			pidf_pkg::S_M_I: begin
				if (mul_done) state_d = pidf_pkg::S_INT_ADD;
			end
			pidf_pkg::S_INT_ADD:   state_d = pidf_pkg::S_INT_CLAMP;
			pidf_pkg::S_INT_CLAMP: state_d = pidf_pkg::S_M_D;
			pidf_pkg::S_M_D: begin
				if (mul_done) state_d = pidf_pkg::S_M_FF;
			end
			pidf_pkg::S_M_FF: begin
				if (mul_done) state_d = pidf_pkg::S_SUM;
			end
			pidf_pkg::S_SUM: state_d = pidf_pkg::S_OUT;
			pidf_pkg::S_OUT: begin
				if (out_free) state_d = pidf_pkg::S_IDLE;
			end
			default: state_d = pidf_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operands
	always_comb begin
		in_stall      = (state_q != pidf_pkg::S_IDLE);
		mul_req.start = 1'b0;
		mul_req.shift = pidf_pkg::SH_NONE;
		op_a          = '0;
		op_b          = '0;
		case (state_q)
			pidf_pkg::S_M_CHANGE, pidf_pkg::S_M_STEP: begin
				mul_req.start = 1'b1;
				mul_req.shift = pidf_pkg::SH_ALPHA;
				op_a          = alpha_op;
				op_b          = t_op;
			end
			pidf_pkg::S_M_DRV, pidf_pkg::S_M_RAW: begin
				mul_req.start = 1'b1;
				op_a          = t_op;
				op_b          = inv_op;
			end
			pidf_pkg::S_M_P: begin
				mul_req.start = 1'b1;
				mul_req.shift = pidf_pkg::SH_FRAC;
				op_a          = OP_W'(filt_q);
				op_b          = OP_W'(kp_q);
			end
			pidf_pkg::S_M_I: begin
				mul_req.start = 1'b1;
				mul_req.shift = pidf_pkg::SH_FRAC;
				op_a          = OP_W'(filt_q);
				op_b          = OP_W'(ki_dt_q);
			end
			pidf_pkg::S_M_D: begin
				mul_req.start = 1'b1;
				mul_req.shift = pidf_pkg::SH_FRAC;
				op_a          = OP_W'(kd_q);
				op_b          = OP_W'(drv_q);
			end
			pidf_pkg::S_M_FF: begin
				mul_req.start = 1'b1;
				mul_req.shift = pidf_pkg::SH_FRAC;
				op_a          = OP_W'(rate_q);
				op_b          = OP_W'(ff_gain_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= '0;
			ki_dt_q   <= '0;
			kd_q      <= '0;
			imax_q    <= '0;
			alpha_q   <= pidf_pkg::ALPHA_ONE;
			inv_dt_q  <= '0;
			mode_q    <= 1'b0;
			ff_gain_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				pidf_pkg::REG_KP:      kp_q      <= cfg_wdata[DATA_WIDTH-1:0];
				pidf_pkg::REG_KI_DT:   ki_dt_q   <= cfg_wdata[DATA_WIDTH-1:0];
				pidf_pkg::REG_KD:      kd_q      <= cfg_wdata[DATA_WIDTH-1:0];
				pidf_pkg::REG_IMAX:    imax_q    <= cfg_wdata[DATA_WIDTH-2:0];
				pidf_pkg::REG_ALPHA:   alpha_q   <= cfg_wdata[pidf_pkg::ALPHA_W-1:0];
				pidf_pkg::REG_INV_DT:  inv_dt_q  <= cfg_wdata[pidf_pkg::INV_DT_W-1:0];
				pidf_pkg::REG_MODE:    mode_q    <= cfg_wdata[0];
				pidf_pkg::REG_FF_GAIN: ff_gain_q <= cfg_wdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= pidf_pkg::S_IDLE;
			filt_q          <= '0;
			drv_q           <= '0;
			integ_q         <= '0;
			first_pending_q <= 1'b1;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				if (first_pending_q) begin
					first_pending_q <= 1'b0;
					filt_q          <= sample;
					drv_q           <= '0;
				end
				if (clear_integrator) integ_q <= '0;
			end
			case (state_q)
				pidf_pkg::S_DIFF: begin
					// raw mode: the filter register simply tracks the sample
					if (mode_q) filt_q <= sample_q;
				end
				pidf_pkg::S_FILT_ADD:  filt_q <= filt_sum;
				pidf_pkg::S_M_DRV: begin
					if (mul_done) drv_q <= mul_res;
				end
				pidf_pkg::S_DRV_ADD:   drv_q <= drv_sum;
				pidf_pkg::S_INT_ADD:   integ_q <= int_sum;
				pidf_pkg::S_INT_CLAMP: integ_q <= int_clamp;
				default: ;
			endcase
			if (state_q == pidf_pkg::S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= sample;
			rate_q   <= rate_setpoint;
			i_q      <= '0;
		end
		case (state_q)
			pidf_pkg::S_DIFF:     t_q <= diff_in;
			pidf_pkg::S_RAW_SUB:  t_q <= raw_sub;
			pidf_pkg::S_M_CHANGE, pidf_pkg::S_M_RAW, pidf_pkg::S_M_STEP,
			pidf_pkg::S_M_I: begin
				if (mul_done) t_q <= mul_res;
			end
			pidf_pkg::S_M_P: begin
				if (mul_done) p_q <= mul_res;
			end
			pidf_pkg::S_INT_CLAMP: i_q <= int_clamp;
			pidf_pkg::S_M_D: begin
				if (mul_done) d_q <= mul_res;
			end
			pidf_pkg::S_M_FF: begin
				if (mul_done) ff_q <= mul_res;
			end
			pidf_pkg::S_SUM: sum_q <= sum3_sat;
			pidf_pkg::S_OUT: begin
				if (out_free) begin
					p_out_q   <= p_q;
					i_out_q   <= i_q;
					d_out_q   <= d_q;
					ff_out_q  <= ff_q;
					sum_out_q <= sum_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign p_term    = p_out_q;
	assign i_term    = i_out_q;
	assign d_term    = d_out_q;
	assign ff_term   = ff_out_q;
	assign pid_sum   = sum_out_q;

endmodule

// ===== sv/pidf_mul.sv =====
// Shared signed multiplier: two half-width partial products, floor shift, saturation.
module pidf_mul #(
	parameter int DATA_WIDTH = pidf_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidf_pkg::FRAC_BITS_DEF,
	localparam int MAG_W = (DATA_WIDTH > pidf_pkg::INV_DT_W) ? DATA_WIDTH : pidf_pkg::INV_DT_W,
	localparam int OP_W  = MAG_W + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pidf_pkg::pidf_mul_req_t       req,
	input  logic signed [OP_W-1:0]        a,
	input  logic signed [OP_W-1:0]        b,
	output logic                          done,
	output logic signed [DATA_WIDTH-1:0]  res
);

	localparam int HW    = (MAG_W + 1) / 2;
	localparam int PW    = MAG_W + HW;
	localparam int ACC_W = MAG_W + 2 * HW + 1;

	pidf_pkg::pidf_mul_state_t st_q, st_d;

	logic [MAG_W-1:0]      a_mag_q, b_mag_q;
	logic                  neg_q;
	pidf_pkg::pidf_shift_t sh_q;
	logic [PW-1:0]         part_lo_q, part_hi_q;
	logic [ACC_W-1:0]      acc_q;

	logic [OP_W-1:0]       a_abs, b_abs;
	logic [HW-1:0]         mul_b;
	logic [PW-1:0]         product;
	logic [ACC_W-1:0]      bias, quot, limit, mag_sat;
	logic [DATA_WIDTH-1:0] mag_lo;

	assign a_abs   = a[OP_W-1] ? $unsigned(-a) : $unsigned(a);
	assign b_abs   = b[OP_W-1] ? $unsigned(-b) : $unsigned(b);
	assign mul_b   = (st_q == pidf_pkg::MS_LO) ? b_mag_q[HW-1:0] : HW'(b_mag_q[MAG_W-1:HW]);
	assign product = PW'(a_mag_q) * PW'(mul_b);

	// negative products round toward minus infinity: add 2^s - 1 to the magnitude
	always_comb begin
		case (sh_q)
			pidf_pkg::SH_ALPHA: begin
				bias = neg_q ? ((ACC_W'(1) << pidf_pkg::ALPHA_BITS) - ACC_W'(1)) : '0;
				quot = acc_q >> pidf_pkg::ALPHA_BITS;
			end
			pidf_pkg::SH_FRAC: begin
				bias = neg_q ? ((ACC_W'(1) << FRAC_BITS) - ACC_W'(1)) : '0;
				quot = acc_q >> FRAC_BITS;
			end
			default: begin
				bias = '0;
				quot = acc_q;
			end
		endcase
	end

	assign limit   = neg_q ? (ACC_W'(1) << (DATA_WIDTH - 1))
	                       : ((ACC_W'(1) << (DATA_WIDTH - 1)) - ACC_W'(1));
	assign mag_sat = (quot > limit) ? limit : quot;
	assign mag_lo  = mag_sat[DATA_WIDTH-1:0];

	always_comb begin
		case (st_q)
			pidf_pkg::MS_IDLE: st_d = req.start ? pidf_pkg::MS_LO : pidf_pkg::MS_IDLE;
			pidf_pkg::MS_LO:   st_d = pidf_pkg::MS_HI;
			pidf_pkg::MS_HI:   st_d = pidf_pkg::MS_ACC;
			pidf_pkg::MS_ACC:  st_d = pidf_pkg::MS_OUT;
			default:           st_d = pidf_pkg::MS_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == pidf_pkg::MS_OUT);
		res  = neg_q ? $signed(-mag_lo) : $signed(mag_lo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pidf_pkg::MS_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			pidf_pkg::MS_IDLE: begin
				if (req.start) begin
					a_mag_q <= a_abs[MAG_W-1:0];
					b_mag_q <= b_abs[MAG_W-1:0];
					neg_q   <= a[OP_W-1] ^ b[OP_W-1];
					sh_q    <= req.shift;
				end
			end
			pidf_pkg::MS_LO:  part_lo_q <= product;
			pidf_pkg::MS_HI:  part_hi_q <= product;
			pidf_pkg::MS_ACC: acc_q <= ACC_W'(part_lo_q) + (ACC_W'(part_hi_q) << HW) + bias;
			default: ;
		endcase
	end

endmodule

// ===== sv/pidf_checker.sv =====
// Port-level checker for the filtered PID controller, bound to the top level.
module pidf_checker #(
	parameter int DATA_WIDTH = pidf_pkg::DATA_WIDTH_DEF,
	localparam int CFG_W = (DATA_WIDTH > pidf_pkg::INV_DT_W) ? DATA_WIDTH : pidf_pkg::INV_DT_W
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_wr_en,
	input logic [pidf_pkg::REG_IDX_W-1:0] cfg_addr,
	input logic [CFG_W-1:0]               cfg_wdata,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [DATA_WIDTH-1:0]   p_term,
	input logic signed [DATA_WIDTH-1:0]   i_term,
	input logic signed [DATA_WIDTH-1:0]   d_term,
	input logic signed [DATA_WIDTH-1:0]   pid_sum
);

	localparam int SW = DATA_WIDTH + 2;
	localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [DATA_WIDTH-2:0]        imax_q;
	logic signed [DATA_WIDTH-1:0] imax_pos, imax_neg, exp_sum;
	logic signed [SW-1:0]         sum3;

	// shadow of the integrator limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imax_q <= '0;
		end else if (cfg_wr_en && cfg_addr == pidf_pkg::REG_IMAX) begin
			imax_q <= cfg_wdata[DATA_WIDTH-2:0];
		end
	end

	assign imax_pos = $signed({1'b0, imax_q});
	assign imax_neg = -imax_pos;
	assign sum3     = SW'(p_term) + SW'(i_term) + SW'(d_term);
	assign exp_sum  = (sum3 > SW'(D_MAX)) ? D_MAX :
	                  (sum3 < SW'(D_MIN)) ? D_MIN : sum3[DATA_WIDTH-1:0];

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again the cycle after a beat");

	a_sum_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pid_sum == exp_sum)
		else $error("pid_sum is not the saturated P+I+D");

	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> i_term >= imax_neg && i_term <= imax_pos)
		else $error("i_term outside the integrator limit");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pid_sum))
		else $error("stalled result dropped or changed");

endmodule

bind pid_controller_filtered pidf_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_pidf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_wr_en (cfg_wr_en),
	.cfg_addr  (cfg_addr),
	.cfg_wdata (cfg_wdata),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.p_term    (p_term),
	.i_term    (i_term),
	.d_term    (d_term),
	.pid_sum   (pid_sum)
);

// ===== verif/tb_top.sv =====
// Testbench for pid_controller_filtered: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_PERIOD = 10;
	localparam int FRAC = pidf_pkg::FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] WORD_HI = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_LO = 32'h8000_0000;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -WORD_MAX - 1;

	typedef struct packed {
		logic [31:0] p;
		logic [31:0] i;
		logic [31:0] d;
		logic [31:0] ff;
		logic [31:0] total;
	} pid_terms_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	pidf_pkg::pidf_reg_t cfg_addr;
	logic [31:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] sample;
	logic signed [31:0] rate_setpoint;
	logic clear_integrator;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] p_term;
	logic signed [31:0] i_term;
	logic signed [31:0] d_term;
	logic signed [31:0] ff_term;
	logic signed [31:0] pid_sum;

	// predictor copy of registers and state
	longint kp_r, ki_r, kd_r, imax_r, alpha_r, invdt_r, ffg_r;
	bit mode_r;
	longint filt_q, drv_q, integ_q;
	bit seed_pending;

	pid_terms_t expected_terms[$];
	int mismatch_count = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int rx_stall_max;
	logic hold_req;
	bit hold_armed = 1'b0;
	int hold_left = 0;
	int rx_left = 0;
	bit rx_stalling = 1'b0;

	pid_controller_filtered DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.rate_setpoint(rate_setpoint),
		.clear_integrator(clear_integrator),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.p_term(p_term),
		.i_term(i_term),
		.d_term(d_term),
		.ff_term(ff_term),
		.pid_sum(pid_sum)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > WORD_MAX)
			return WORD_MAX;
		if (v < WORD_MIN)
			return WORD_MIN;
		return v;
	endfunction

	// exact product, floor shift, saturate
	function automatic longint mul_floor(longint a, longint b, int sh);
		longint prod;
		prod = a * b;
		return clip32(prod >>> sh);
	endfunction

	function automatic void clear_pid_state();
		kp_r = 0; ki_r = 0; kd_r = 0; imax_r = 0;
		alpha_r = 65536; invdt_r = 0; mode_r = 1'b0; ffg_r = 0;
		filt_q = 0; drv_q = 0; integ_q = 0;
		seed_pending = 1'b1;
	endfunction

	function automatic void load_pid_reg(pidf_pkg::pidf_reg_t idx, logic [31:0] v);
		case (idx)
			pidf_pkg::REG_KP: kp_r = longint'(signed'(v));
			pidf_pkg::REG_KI_DT: ki_r = longint'(signed'(v));
			pidf_pkg::REG_KD: kd_r = longint'(signed'(v));
			pidf_pkg::REG_IMAX: imax_r = longint'(v[30:0]);
			pidf_pkg::REG_ALPHA: alpha_r = longint'(v[16:0]);
			pidf_pkg::REG_INV_DT: invdt_r = longint'(v[19:0]);
			pidf_pkg::REG_MODE: mode_r = v[0];
			pidf_pkg::REG_FF_GAIN: ffg_r = longint'(signed'(v));
			default: ;
		endcase
	endfunction

	function automatic pid_terms_t predict_terms(logic [31:0] smp_w, logic [31:0] rate_w,
			logic clr);
		longint smp, rate, a, diff, chg, raw, stp, p, i, d, ff, total;
		pid_terms_t r;
		smp = longint'(signed'(smp_w));
		rate = longint'(signed'(rate_w));
		a = (alpha_r > 65536) ? 65536 : alpha_r;
		if (seed_pending) begin
			seed_pending = 1'b0;
			filt_q = smp;
			drv_q = 0;
		end
		if (!mode_r) begin
			diff = clip32(smp - filt_q);
			chg = mul_floor(a, diff, pidf_pkg::ALPHA_BITS);
			filt_q = clip32(filt_q + chg);
			if (invdt_r != 0)
				drv_q = mul_floor(chg, invdt_r, 0);
		end else begin
			if (invdt_r != 0) begin
				raw = mul_floor(clip32(smp - filt_q), invdt_r, 0);
				stp = mul_floor(a, clip32(raw - drv_q), pidf_pkg::ALPHA_BITS);
				drv_q = clip32(drv_q + stp);
			end
			filt_q = smp;
		end
		p = mul_floor(filt_q, kp_r, FRAC);
		if (clr)
			integ_q = 0;
		if (ki_r != 0) begin
			integ_q = clip32(integ_q + mul_floor(filt_q, ki_r, FRAC));
			if (integ_q < -imax_r)
				integ_q = -imax_r;
			else if (integ_q > imax_r)
				integ_q = imax_r;
			i = integ_q;
		end else begin
			i = 0;
		end
		d = mul_floor(kd_r, drv_q, FRAC);
		ff = mul_floor(rate, ffg_r, FRAC);
		total = clip32(p + i + d);
		r.p = p[31:0];
		r.i = i[31:0];
		r.d = d[31:0];
		r.ff = ff[31:0];
		r.total = total[31:0];
		return r;
	endfunction

	task automatic check_terms();
		pid_terms_t want, got;
		got = '{p_term, i_term, d_term, ff_term, pid_sum};
		results_seen++;
		if (expected_terms.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: result %0d arrived with nothing expected", $time, results_seen);
		end else begin
			want = expected_terms.pop_front();
			if (want.p != got.p || want.i != got.i || want.d != got.d ||
					want.ff != got.ff || want.total != got.total) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%0t: result %0d exp P %h I %h D %h FF %h SUM %h", $time,
						results_seen, want.p, want.i, want.d, want.ff, want.total);
					$display("%0t: result %0d got P %h I %h D %h FF %h SUM %h", $time,
						results_seen, got.p, got.i, got.d, got.ff, got.total);
				end
			end
		end
	endtask

	// receiver: checks beats, stalls in random runs, or holds off on request
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			check_terms();
		if (hold_req === 1'b1 && !hold_armed) begin
			hold_armed = 1'b1;
			hold_left = HOLD_CYCLES;
		end else if (hold_req !== 1'b1) begin
			hold_armed = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_stall_max == 0) begin
			out_stall <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left--;
		end else begin
			rx_stalling = !rx_stalling;
			rx_left = rx_stalling ? $urandom_range(rx_stall_max, 0) : $urandom_range(10, 0);
			out_stall <= rx_stalling;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	task automatic set_reg(pidf_pkg::pidf_reg_t idx, logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		load_pid_reg(idx, v);
	endtask

	task automatic set_all(logic [31:0] kp, logic [31:0] ki_dt, logic [31:0] kd,
			logic [31:0] imax, logic [31:0] alpha, logic [31:0] inv_dt, logic [31:0] mode,
			logic [31:0] ff_gain);
		set_reg(pidf_pkg::REG_KP, kp);
		set_reg(pidf_pkg::REG_KI_DT, ki_dt);
		set_reg(pidf_pkg::REG_KD, kd);
		set_reg(pidf_pkg::REG_IMAX, imax);
		set_reg(pidf_pkg::REG_ALPHA, alpha);
		set_reg(pidf_pkg::REG_INV_DT, inv_dt);
		set_reg(pidf_pkg::REG_MODE, mode);
		set_reg(pidf_pkg::REG_FF_GAIN, ff_gain);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_beat(logic [31:0] smp, logic [31:0] rate, logic clr);
		sample <= smp;
		rate_setpoint <= rate;
		clear_integrator <= clr;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_terms.push_back(predict_terms(smp, rate, clr));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_terms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word(logic [31:0] prev);
		logic [31:0] w;
		case ($urandom_range(5, 0))
			0: w = $urandom();
			1: begin
				case ($urandom_range(3, 0))
					0: w = WORD_HI;
					1: w = WORD_LO;
					2: w = 32'h0;
					default: w = 32'hFFFF_FFFF;
				endcase
			end
			2, 3: w = prev + $urandom_range(32'h3_FFFF, 0) - 32'h1_FFFF;   // slow drift
			default: w = $urandom_range(32'h7_FFFF, 0) - 32'h3_FFFF;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(5, 0))
			0: return $urandom();
			1: return $urandom_range(1, 0) ? WORD_HI : WORD_LO;
			2: return 32'h0;
			default: return $urandom_range(32'h3_FFFF, 0) - 32'h1_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_imax();
		case ($urandom_range(3, 0))
			0: return $urandom() & WORD_HI;
			1: return 32'h0;
			2: return WORD_HI;
			default: return $urandom_range(32'h7_FFFF, 0);
		endcase
	endfunction

	function automatic logic [31:0] pick_alpha();
		case ($urandom_range(3, 0))
			0: return 32'd65536;
			1: return $urandom_range(131071, 65537);
			2: return $urandom_range(4096, 0);
			default: return $urandom_range(65536, 0);
		endcase
	endfunction

	function automatic logic [31:0] pick_inv_dt();
		case ($urandom_range(3, 0))
			0: return 32'h0;
			1: return 32'h000F_FFFF;
			2: return $urandom_range(1000000, 1);
			default: return $urandom_range(1000, 1);
		endcase
	endfunction

	task automatic send_stream(int n, int gap_max, int burst_max);
		logic [31:0] smp, rate;
		int burst_left, gap;
		smp = 32'h0;
		rate = 32'h0;
		burst_left = $urandom_range(burst_max, 1);
		for (int k = 0; k < n; k++) begin
			smp = pick_word(smp);
			rate = pick_word(rate);
			send_beat(smp, rate, $urandom_range(9, 0) == 0);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(burst_max, 1);
				gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// mode 1 before the first beat: seeding must zero the derivative
	task automatic test_first_sample_seed();
		set_all(ONE, 32'h0000_4000, ONE, WORD_HI, 32'h0000_8000, 32'd100, 32'd1, ONE);
		send_beat(32'h0005_0000, WORD_HI, 1'b0);
		send_beat(WORD_HI, WORD_LO, 1'b0);
		send_beat(WORD_LO, 32'h0, 1'b1);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_input_filter();
		// alpha above one acts as one
		set_all(32'h0002_0000, 32'h0, 32'hFFFF_0000, 32'h0010_0000, 32'h0001_FFFF,
			32'd1000000, 32'd0, 32'hFFFF_0000);
		send_beat(32'h0, ONE, 1'b0);
		send_beat(WORD_HI, WORD_HI, 1'b0);
		send_beat(WORD_LO, WORD_LO, 1'b0);
		drain_pipeline();
		set_all(ONE, 32'h0, ONE, 32'h0, 32'h0, 32'd1000, 32'd0, ONE);
		send_beat(WORD_HI, 32'h0, 1'b0);
		send_beat(32'h1234_5678, 32'h0, 1'b0);
		drain_pipeline();
		set_all(ONE, 32'h0, ONE, 32'h0, 32'h1, 32'd1000, 32'd0, ONE);
		send_beat(WORD_LO, 32'h0, 1'b0);
		send_beat(WORD_HI, 32'h0, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_derivative_hold();
		set_all(ONE, 32'h0, WORD_HI, 32'h0, 32'h0000_4000, 32'h0, 32'd0, 32'h0);
		send_beat(32'h0003_0000, 32'h0, 1'b0);
		send_beat(32'hFFF0_0000, 32'h0, 1'b0);
		drain_pipeline();
		set_all(ONE, 32'h0, WORD_HI, 32'h0, 32'h0000_4000, 32'h0, 32'd1, 32'h0);
		send_beat(32'h0100_0000, 32'h0, 1'b0);
		send_beat(32'h0, 32'h0, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_integrator();
		// zero gain: clear still empties the integrator, the I term stays zero
		set_all(ONE, 32'h0, 32'h0, 32'h0, 32'd65536, 32'd10, 32'd0, 32'h0);
		send_beat(32'h0002_0000, 32'h0, 1'b1);
		send_beat(32'h0002_0000, 32'h0, 1'b0);
		drain_pipeline();
		set_all(32'h0, WORD_HI, 32'h0, WORD_HI, 32'd65536, 32'h0, 32'd0, 32'h0);
		send_beat(WORD_HI, 32'h0, 1'b0);
		send_beat(WORD_HI, 32'h0, 1'b0);
		send_beat(WORD_LO, 32'h0, 1'b1);
		drain_pipeline();
		set_all(32'h0, WORD_LO, 32'h0, 32'h0, 32'd65536, 32'h0, 32'd1, 32'h0);
		send_beat(32'h0001_0000, 32'h0, 1'b0);
		send_beat(32'hFFFF_0000, 32'h0, 1'b1);
		drain_pipeline();
	endtask

	task automatic test_saturation();
		set_all(WORD_LO, WORD_LO, WORD_LO, WORD_HI, 32'd65536, 32'h000F_FFFF, 32'd0, WORD_LO);
		send_beat(WORD_LO, WORD_LO, 1'b0);
		send_beat(WORD_HI, WORD_HI, 1'b0);
		drain_pipeline();
	endtask

	// long receiver hold while the sender keeps offering beats
	task automatic test_output_backpressure();
		set_all(pick_gain(), pick_gain(), pick_gain(), pick_imax(), pick_alpha(),
			pick_inv_dt(), $urandom_range(1, 0), pick_gain());
		rx_stall_max <= 0;
		hold_req <= 1'b1;
		send_stream(16, 0, 16);
		drain_pipeline();
		hold_req <= 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 6; ph++) begin
			set_all(pick_gain(), pick_gain(), pick_gain(), pick_imax(), pick_alpha(),
				pick_inv_dt(), $urandom_range(1, 0), pick_gain());
			rx_stall_max <= (ph == 0) ? 0 : $urandom_range(20, 1);
			if (ph == 0)
				send_stream(100, 0, 8);
			else
				send_stream(100, $urandom_range(15, 1), $urandom_range(8, 1));
			drain_pipeline();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= pidf_pkg::REG_KP;
		cfg_wdata <= 32'h0;
		in_valid <= 1'b0;
		sample <= 32'h0;
		rate_setpoint <= 32'h0;
		clear_integrator <= 1'b0;
		rx_stall_max <= 0;
		hold_req <= 1'b0;
		clear_pid_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample_seed();
		test_input_filter();
		test_derivative_hold();
		test_integrator();
		test_saturation();
		test_output_backpressure();
		test_random_traffic();

		drain_pipeline();
		if (mismatch_count == 0 && expected_terms.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/pidf_pkg.sv
sv/pidf_mul.sv
sv/pid_controller_filtered.sv
sv/pidf_checker.sv
verif/tb_top.sv
